/* rtl/itic_pkg.sv */
package itic_pkg;

   localparam int TIMER_LINE   = 1;
   localparam int VECTOR_LINES = 16;
   localparam int LINE_COUNT   = 16;
   localparam int WORD_WIDTH   = 32;
   localparam int BASE_LINE    = 8;
   localparam int VEC_IDX_W    = 5;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic [2:0] REG_VECTOR = 3'd0;
   localparam logic [2:0] REG_RELOAD = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_MASK   = 3'd3;

   typedef struct packed {
      logic [1:0]            command;
      logic [2:0]            register_select;
      logic [WORD_WIDTH-1:0] write_data;
      logic [LINE_COUNT-1:0] asserted_lines;
   } req_word_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] read_data;
      logic                  timer_irq_raise;
      logic                  timer_irq_ack;
      logic                  base_line_ack;
      logic                  unimplemented;
   } rsp_word_type;

endpackage

/* rtl/interval_timer_interrupt_controller_top.sv */
// Interval timer and interrupt controller.
// Request channel (req_valid, req_stall, req_word) carries one word per
// access: a timer tick, a register read or a register write. Response
// channel (rsp_valid, rsp_stall, rsp_word) returns exactly one word per
// request, in order, with the read data and the raise/ack/unimplemented
// flags.
// A request is taken into the input register, processed against the timer
// and mask state as it moves to the output register, and appears on rsp_
// right after that edge.
// Throughput is one word per cycle while rsp_stall is low; the whole update
// is a single pass of logic between the input and output registers.
// Reset clears the reload value, countdown, enable mask and both valid
// flags; there is no initialization pass.
// While rsp_stall holds, the output word stays put and the input register
// still takes one more word; req_stall rises only when both are full.
module interval_timer_interrupt_controller_top #(
   parameter int TIMER_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  itic_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output itic_pkg::rsp_word_type rsp_word
);

   logic s1_valid_ff, s1_valid_in;
   itic_pkg::req_word_type s1_word_ff, s1_word_in;
   logic rsp_valid_ff, rsp_valid_in;
   itic_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   itic_pkg::rsp_word_type core_result;

   logic out_free;
   logic s1_move;
   logic req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   itic_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .advance(s1_move),
      .word   (s1_word_ff),
      .result (core_result)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_word_in   = s1_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_word_in  = req_word;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_word_in = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipe");

   a_move_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("word lost between stages");

   a_take_fills_in: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted word not held in input register");

endmodule

/* rtl/itic_core.sv */
module itic_core #(
   parameter int TIMER_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  itic_pkg::req_word_type word,
   output itic_pkg::rsp_word_type result
);

   logic [TIMER_WIDTH-1:0] reload_ff, reload_in;
   logic [TIMER_WIDTH-1:0] countdown_ff, countdown_in;
   logic [itic_pkg::WORD_WIDTH-1:0] mask_ff, mask_in;

   logic [63:0] wdata_wide;
   logic [63:0] reload_wide;
   logic [63:0] count_wide;
   logic [itic_pkg::LINE_COUNT-1:0] pending;
   logic [itic_pkg::VEC_IDX_W-1:0] vec_idx;
   logic is_write;
   logic tick_ok;

   assign wdata_wide  = {32'b0, word.write_data};
   assign reload_wide = 64'(reload_ff);
   assign count_wide  = 64'(countdown_ff);
   assign pending     = word.asserted_lines & mask_ff[itic_pkg::LINE_COUNT-1:0];
   assign is_write    = (word.command == itic_pkg::CMD_WRITE);
   assign tick_ok     = (reload_ff != '0) && (countdown_ff != '0)
                        && mask_ff[itic_pkg::TIMER_LINE];

   always_comb begin
      vec_idx = '0;
      for (int i = itic_pkg::LINE_COUNT - 1; i >= 0; i--) begin
         if (i < itic_pkg::VECTOR_LINES && pending[i]) begin
            vec_idx = itic_pkg::VEC_IDX_W'(i);
         end
      end
   end

   always_comb begin
      reload_in    = reload_ff;
      countdown_in = countdown_ff;
      mask_in      = mask_ff;
      result       = '0;
      case (word.command)
         itic_pkg::CMD_TICK: begin
            if (tick_ok) begin
               countdown_in = countdown_ff - TIMER_WIDTH'(1);
               result.timer_irq_raise = (countdown_ff == TIMER_WIDTH'(1));
            end
         end
         itic_pkg::CMD_READ, itic_pkg::CMD_WRITE: begin
            case (word.register_select)
               itic_pkg::REG_VECTOR: begin
                  if (!is_write) begin
                     result.read_data = itic_pkg::WORD_WIDTH'(vec_idx);
                  end
               end
               itic_pkg::REG_RELOAD: begin
                  if (is_write) begin
                     reload_in    = wdata_wide[TIMER_WIDTH-1:0];
                     countdown_in = wdata_wide[TIMER_WIDTH-1:0];
                  end else begin
                     result.read_data = reload_wide[itic_pkg::WORD_WIDTH-1:0];
                  end
               end
               itic_pkg::REG_STATUS: begin
                  result.timer_irq_ack = 1'b1;
                  if (!is_write) begin
                     result.read_data = count_wide[itic_pkg::WORD_WIDTH-1:0];
                  end
                  countdown_in = reload_ff;
               end
               itic_pkg::REG_MASK: begin
                  if (is_write) begin
                     mask_in              = word.write_data;
                     result.base_line_ack = 1'b1;
                  end else begin
                     result.read_data = mask_ff;
                  end
               end
               default: begin
                  result.unimplemented = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= '0;
         countdown_ff <= '0;
         mask_ff      <= '0;
      end else if (advance) begin
         reload_ff    <= reload_in;
         countdown_ff <= countdown_in;
         mask_ff      <= mask_in;
      end
   end

   a_count_le_reload: assert property (@(posedge clock) disable iff (reset)
      countdown_ff <= reload_ff)
      else $error("countdown exceeds reload value");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (countdown_ff == '0) && (reload_ff == '0) && (mask_ff == '0))
      else $error("state not cleared by reset");

   a_raise_hits_zero: assert property (@(posedge clock) disable iff (reset)
      advance && result.timer_irq_raise |=> countdown_ff == '0)
      else $error("raise without countdown at zero");

endmodule
